@@ rtl/pps_pkg.sv @@
// Shared types and constants for the preemptive priority scheduler.
package pps_pkg;

    localparam int MAX_PROCS_DEF = 16;
    localparam int ARR_W         = 16;
    localparam int BUR_W         = 16;
    localparam int PRI_W         = 8;
    localparam int CLK_W         = 24;
    localparam int PID_W         = 5;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic [ARR_W-1:0] arrive;
        logic [BUR_W-1:0] burst;
        logic [BUR_W-1:0] remain;
        logic [PRI_W-1:0] prio;
    } t_rec;

    // comparator verdict on the entry just read
    typedef struct packed {
        logic take;
    } t_cmp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_UPD,
        ST_RES
    } t_state;

endpackage

@@ rtl/pps_table.sv @@
// Process table: record memory with one write and one registered read port, plus done flags.
module pps_table #(
    parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF,
    localparam int IW = $clog2(MAX_PROCS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [IW-1:0] i_wr_addr,
    input  pps_pkg::t_rec i_wr_rec,
    input  logic          i_done_set,
    input  logic          i_done_clr,
    input  logic [IW-1:0] i_rd_addr,
    output pps_pkg::t_rec o_rd_rec,
    output logic          o_rd_done
);

    pps_pkg::t_rec        mem [MAX_PROCS];
    logic [MAX_PROCS-1:0] r_done;
    pps_pkg::t_rec        r_rd_rec;
    logic                 r_rd_done;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_rec;
        end
        r_rd_rec <= mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done    <= '0;
            r_rd_done <= 1'b0;
        end else begin
            if (i_done_set) begin
                r_done[i_wr_addr] <= 1'b1;
            end else if (i_done_clr) begin
                r_done[i_wr_addr] <= 1'b0;
            end
            r_rd_done <= r_done[i_rd_addr];
        end
    end

    assign o_rd_rec  = r_rd_rec;
    assign o_rd_done = r_rd_done;

endmodule

@@ rtl/pps_cmp.sv @@
// Shared compare unit: eligibility and priority ordering against the best entry so far.
module pps_cmp (
    input  pps_pkg::t_rec                 i_rec,
    input  logic                          i_done,
    input  logic [pps_pkg::CLK_W-1:0]     i_now,
    input  pps_pkg::t_rec                 i_best,
    input  logic                          i_found,
    output pps_pkg::t_cmp                 o_cmp
);

    logic arrived;
    logic better;

    assign arrived = (pps_pkg::CLK_W'(i_rec.arrive) <= i_now);
    // scan runs in id order, so a full tie keeps the earlier id
    assign better  = !i_found
                   || (i_rec.prio < i_best.prio)
                   || ((i_rec.prio == i_best.prio) && (i_rec.arrive < i_best.arrive));

    assign o_cmp.take = arrived && !i_done && better;

endmodule

@@ rtl/preemptive_priority_scheduler_top.sv @@
// Preemptive priority scheduler: sequencer, table and compare unit.
// A load item is written into the table when accepted; busy stays low and no result follows.
// A tick item keeps busy high while the sequencer steps through its states (update and result only when empty):
// a scan state over each loaded entry through the single read port, a last compare, update and result.
// o_valid is registered from the result state; receiver cannot stall.
// Synchronous active-low reset clears the counts, clock, done flags and control state.
module preemptive_priority_scheduler_top #(
    parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF,
    localparam int IW = $clog2(MAX_PROCS),
    localparam int CW = $clog2(MAX_PROCS + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_op,
    input  logic [pps_pkg::ARR_W-1:0]     i_arrival,
    input  logic [pps_pkg::BUR_W-1:0]     i_burst,
    input  logic [pps_pkg::PRI_W-1:0]     i_prio,
    output logic                          o_valid,
    output logic                          o_idle,
    output logic [pps_pkg::PID_W-1:0]     o_proc_id,
    output logic [pps_pkg::CLK_W-1:0]     o_tick_start,
    output logic                          o_finished,
    output logic [pps_pkg::CLK_W-1:0]     o_turnaround,
    output logic [pps_pkg::CLK_W-1:0]     o_waiting,
    output logic                          o_all_done
);

    pps_pkg::t_state r_state, n_state;

    logic [CW-1:0]             r_loaded;
    logic [CW-1:0]             r_fin_cnt;
    logic [pps_pkg::CLK_W-1:0] r_clock;
    logic [pps_pkg::CLK_W-1:0] r_start;
    logic [IW-1:0]             r_idx;
    logic                      r_rv;
    logic [IW-1:0]             r_rv_idx;
    logic                      r_found;
    logic [IW-1:0]             r_best_idx;
    pps_pkg::t_rec             r_best;
    logic                      r_finish;
    logic [pps_pkg::CLK_W-1:0] r_tat;

    logic                      r_valid;
    logic                      r_idle;
    logic [pps_pkg::PID_W-1:0] r_pid;
    logic [pps_pkg::CLK_W-1:0] r_tick_start;
    logic                      r_fin_o;
    logic [pps_pkg::CLK_W-1:0] r_tat_o;
    logic [pps_pkg::CLK_W-1:0] r_wait_o;
    logic                      r_all_done;

    logic          accept;
    logic          do_load;
    logic          scan_last;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    pps_pkg::t_rec wr_rec;
    logic          done_set;
    logic          done_clr;
    logic [IW-1:0] rd_addr;
    pps_pkg::t_rec rd_rec;
    logic          rd_done;
    pps_pkg::t_cmp cmp;
    logic          ends_now;
    logic [pps_pkg::BUR_W-1:0] dec_remain;

    assign busy      = (r_state != pps_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign do_load   = accept && (i_op == pps_pkg::OP_LOAD) && (r_loaded < CW'(MAX_PROCS));
    assign scan_last = (CW'(r_idx) == (r_loaded - CW'(1)));
    assign ends_now  = (r_best.remain <= pps_pkg::BUR_W'(1));
    assign dec_remain = ends_now ? '0 : (r_best.remain - pps_pkg::BUR_W'(1));

    pps_table #(
        .MAX_PROCS (MAX_PROCS)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_rec   (wr_rec),
        .i_done_set (done_set),
        .i_done_clr (done_clr),
        .i_rd_addr  (rd_addr),
        .o_rd_rec   (rd_rec),
        .o_rd_done  (rd_done)
    );

    pps_cmp u_cmp (
        .i_rec   (rd_rec),
        .i_done  (rd_done),
        .i_now   (r_start),
        .i_best  (r_best),
        .i_found (r_found),
        .o_cmp   (cmp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pps_pkg::ST_IDLE: begin
                if (accept && (i_op == pps_pkg::OP_TICK)) begin
                    n_state = (r_loaded == '0) ? pps_pkg::ST_UPD : pps_pkg::ST_SCAN;
                end
            end
            pps_pkg::ST_SCAN: begin
                if (scan_last) begin
                    n_state = pps_pkg::ST_LAST;
                end
            end
            pps_pkg::ST_LAST: n_state = pps_pkg::ST_UPD;
            pps_pkg::ST_UPD:  n_state = pps_pkg::ST_RES;
            pps_pkg::ST_RES:  n_state = pps_pkg::ST_IDLE;
            default:          n_state = pps_pkg::ST_IDLE;
        endcase
    end

    // table control
    always_comb begin
        wr_en    = 1'b0;
        wr_addr  = r_best_idx;
        wr_rec   = r_best;
        done_set = 1'b0;
        done_clr = 1'b0;
        rd_addr  = r_idx;
        unique case (r_state)
            pps_pkg::ST_IDLE: begin
                wr_en    = do_load;
                done_clr = do_load;
                wr_addr  = r_loaded[IW-1:0];
                wr_rec   = '{arrive: i_arrival, burst: i_burst, remain: i_burst, prio: i_prio};
            end
            pps_pkg::ST_UPD: begin
                wr_en         = r_found;
                done_set      = r_found && ends_now;
                wr_rec.remain = dec_remain;
            end
            pps_pkg::ST_SCAN, pps_pkg::ST_LAST, pps_pkg::ST_RES: begin
                wr_en = 1'b0;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pps_pkg::ST_IDLE;
            r_loaded  <= '0;
            r_fin_cnt <= '0;
            r_clock   <= '0;
            r_rv      <= 1'b0;
            r_found   <= 1'b0;
            r_finish  <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            r_rv    <= (r_state == pps_pkg::ST_SCAN);
            if (do_load) begin
                r_loaded <= r_loaded + CW'(1);
            end
            if (accept && (i_op == pps_pkg::OP_TICK)) begin
                r_found <= 1'b0;
            end else if (r_rv && cmp.take) begin
                r_found <= 1'b1;
            end
            if (r_state == pps_pkg::ST_UPD) begin
                r_clock  <= r_start + pps_pkg::CLK_W'(1);
                r_finish <= r_found && ends_now;
                if (r_found && ends_now) begin
                    r_fin_cnt <= r_fin_cnt + CW'(1);
                end
            end
            if (r_state == pps_pkg::ST_RES) begin
                r_valid <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept && (i_op == pps_pkg::OP_TICK)) begin
            r_idx   <= '0;
            r_start <= r_clock;
        end else if ((r_state == pps_pkg::ST_SCAN) && !scan_last) begin
            r_idx <= r_idx + IW'(1);
        end
        r_rv_idx <= r_idx;
        if (r_rv && cmp.take) begin
            r_best_idx <= r_rv_idx;
            r_best     <= rd_rec;
        end
        if (r_state == pps_pkg::ST_UPD) begin
            // completion is start + 1, modulo the clock width
            r_tat <= r_start + pps_pkg::CLK_W'(1) - pps_pkg::CLK_W'(r_best.arrive);
        end
        if (r_state == pps_pkg::ST_RES) begin
            r_idle       <= !r_found;
            r_pid        <= r_found ? pps_pkg::PID_W'({1'b0, r_best_idx} + (IW+1)'(1)) : '0;
            r_tick_start <= r_start;
            r_fin_o      <= r_finish;
            r_tat_o      <= r_finish ? r_tat : '0;
            r_wait_o     <= (r_finish && (r_tat >= pps_pkg::CLK_W'(r_best.burst)))
                            ? (r_tat - pps_pkg::CLK_W'(r_best.burst)) : '0;
            r_all_done   <= (r_fin_cnt == r_loaded);
        end
    end

    assign o_valid      = r_valid;
    assign o_idle       = r_idle;
    assign o_proc_id    = r_pid;
    assign o_tick_start = r_tick_start;
    assign o_finished   = r_fin_o;
    assign o_turnaround = r_tat_o;
    assign o_waiting    = r_wait_o;
    assign o_all_done   = r_all_done;

    a_valid_after_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == pps_pkg::ST_RES))
        else $error("result strobe without result cycle");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_idle) |-> ((o_proc_id == '0) && !o_finished))
        else $error("idle result carries a process");

    a_fin_le_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_cnt <= r_loaded)
        else $error("more finished than loaded");

    a_wait_le_tat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_finished) |-> (o_waiting <= o_turnaround))
        else $error("waiting exceeds turnaround");

endmodule
